// ----- rtl/etsc_pkg.sv -----
// Package for the expression token syntax checker: item codes, state and result types.
package etsc_pkg;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_POINT  = 8'h2E;  // '.'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_CR     = 8'h0D;  // '\r'
  localparam logic [7:0] CH_LF     = 8'h0A;  // '\n'
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;

  localparam int unsigned ERR_POS_W = 16;

  typedef enum logic [2:0] {
    IT_NONE  = 3'd0,
    IT_NUM   = 3'd1,
    IT_OPEN  = 3'd2,
    IT_CLOSE = 3'd3,
    IT_OP    = 3'd4,
    IT_SIGN  = 3'd5,
    IT_FUNC  = 3'd6
  } item_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_NUM  = 2'd1,
    PK_NAME = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    ST_FINE     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_ERROR    = 2'd2,
    ST_UNCLOSED = 2'd3
  } status_t;

  // Tokenizer control state
  typedef struct packed {
    item_t prev;
    item_t older;
    pend_t pend;
    logic  num_flag;
    logic  name_flag;
    logic  point_seen;
    logic  err;
  } tok_state_t;

  typedef struct packed {
    status_t              status;
    logic [ERR_POS_W-1:0] err_pos;
    item_t                item;
  } result_t;

endpackage

// ----- rtl/etsc_if.sv -----
// Valid/ready channel interfaces for the character input and the verdict output.
interface etsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface etsc_out_if;
  logic              valid;
  logic              ready;
  etsc_pkg::status_t status;
  logic [15:0]       err_pos;
  etsc_pkg::item_t   last_item_type;

  modport source (output valid, output status, output err_pos, output last_item_type,
                  input ready);
  modport sink   (input valid, input status, input err_pos, input last_item_type,
                  output ready);
endinterface

// ----- rtl/expression_token_syntax_checker.sv -----
// Top level of the streaming expression token syntax checker.
//
//  channel   | dir | payload                          | transaction
//  ----------+-----+----------------------------------+----------------------------
//  in_port   | in  | ch[7:0], last                    | one character of the text
//  out_port  | out | status[1:0], err_pos[15:0],      | one verdict per character
//            |     | last_item_type[2:0]              |
//
//  One character per cycle: the step logic reads the tokenizer state and the
//  character, and the verdict lands in the output register on the same edge.
//  A new transaction is taken while the output register is empty or drained
//  in the same cycle; a stalled output holds the input back.
//  Reset (rst_n low, synchronous) clears the tokenizer state and the output valid;
//  a transaction with last set returns the state to its reset value.
module expression_token_syntax_checker #(
  parameter int DEPTH_BITS    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  etsc_in_if.sink    in_port,
  etsc_out_if.source out_port
);
  import etsc_pkg::*;

  // Tokenizer state
  tok_state_t               st_r, st_nxt;
  logic [DEPTH_BITS-1:0]    depth_r, depth_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] err_at_r, err_at_nxt;

  // Output register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic in_fire;

  // Accept while the output slot is free or being emptied this cycle
  assign in_port.ready = !out_valid_r || out_port.ready;
  assign in_fire       = in_port.valid && in_port.ready;

  etsc_step #(
    .DEPTH_BITS   (DEPTH_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .ch        (in_port.ch),
    .last      (in_port.last),
    .st        (st_r),
    .depth     (depth_r),
    .pos       (pos_r),
    .err_at    (err_at_r),
    .st_nxt    (st_nxt),
    .depth_nxt (depth_nxt),
    .pos_nxt   (pos_nxt),
    .err_at_nxt(err_at_nxt),
    .res       (res_nxt)
  );

  // State: the final character returns everything to the reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '{prev: IT_NONE, older: IT_NONE, pend: PK_NONE, default: 1'b0};
      depth_r  <= '0;
      pos_r    <= '0;
      err_at_r <= '0;
    end else if (in_fire) begin
      if (in_port.last) begin
        st_r     <= '{prev: IT_NONE, older: IT_NONE, pend: PK_NONE, default: 1'b0};
        depth_r  <= '0;
        pos_r    <= '0;
        err_at_r <= '0;
      end else begin
        st_r     <= st_nxt;
        depth_r  <= depth_nxt;
        pos_r    <= pos_nxt;
        err_at_r <= err_at_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_port.valid          = out_valid_r;
  assign out_port.status         = res_r.status;
  assign out_port.err_pos        = res_r.err_pos;
  assign out_port.last_item_type = res_r.item;

`ifndef SYNTHESIS
  // Position freezes at the failing character
  a_err_pos_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.err |-> (err_at_r == pos_r))
    else $error("latched error position differs from frozen position");

  // Final character clears the stream state
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_port.last) |=> (depth_r == '0 && pos_r == '0 && !st_r.err))
    else $error("state not cleared after final character");

  // A clean non-final character advances the position by one
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_port.last && !st_nxt.err) |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("position did not advance");

  // An accepted character always produces a verdict in the next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // Errors report the error status in the same verdict
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_nxt.err) |=> (res_r.status == ST_ERROR))
    else $error("latched error without error status");
`endif

endmodule

// ----- rtl/etsc_step.sv -----
// Combinational per-character update: tokenizer, adjacency check, bracket depth, verdict.
module etsc_step #(
  parameter int DEPTH_BITS    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic [7:0]               ch,
  input  logic                     last,
  input  etsc_pkg::tok_state_t     st,
  input  logic [DEPTH_BITS-1:0]    depth,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [POSITION_BITS-1:0] err_at,
  output etsc_pkg::tok_state_t     st_nxt,
  output logic [DEPTH_BITS-1:0]    depth_nxt,
  output logic [POSITION_BITS-1:0] pos_nxt,
  output logic [POSITION_BITS-1:0] err_at_nxt,
  output etsc_pkg::result_t        res
);
  import etsc_pkg::*;

  localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};

  function automatic logic pair_ok(input item_t a, input item_t b);
    logic r;
    case (a)
      IT_NUM, IT_CLOSE: r = (b == IT_OP) || (b == IT_CLOSE);
      IT_OPEN, IT_OP:   r = (b != IT_OP) && (b != IT_CLOSE);
      IT_SIGN:          r = (b == IT_NUM) || (b == IT_OPEN);
      IT_FUNC:          r = (b == IT_OPEN);
      default:          r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic tok_state_t push(input tok_state_t s, input item_t t);
    tok_state_t r;
    r       = s;
    r.older = s.prev;
    r.prev  = t;
    return r;
  endfunction

  // Name flush clears only the name flag, number flush only the number flag.
  function automatic tok_state_t flush(input tok_state_t s);
    tok_state_t r;
    r = s;
    case (s.pend)
      PK_NAME: begin
        r           = push(s, IT_FUNC);
        r.name_flag = 1'b0;
      end
      PK_NUM: begin
        r          = push(s, IT_NUM);
        r.num_flag = 1'b0;
      end
      default: ;
    endcase
    r.pend = PK_NONE;
    return r;
  endfunction

  tok_state_t                s;
  logic [DEPTH_BITS-1:0]     d;
  logic [POSITION_BITS-1:0]  p;
  logic [POSITION_BITS-1:0]  ea;
  logic                      ok;
  logic [31:0]               wide_pos;

  always_comb begin
    s  = st;
    d  = depth;
    p  = pos;
    ea = err_at;
    ok = 1'b1;

    if (!st.err) begin
      if (pos == POS_MAX) begin
        ok = 1'b0;
      end else if (ch inside {[CH_DIG_LO:CH_DIG_HI], CH_POINT}) begin
        if (!s.num_flag) begin
          if (s.prev == IT_NUM) begin
            ok = 1'b0;
          end else begin
            s.num_flag   = 1'b1;
            s.point_seen = 1'b0;
          end
        end
        if (ok && ch == CH_POINT) begin
          if (s.point_seen) ok = 1'b0;
          else s.point_seen = 1'b1;
        end
        if (ok && s.pend == PK_NONE) s.pend = PK_NUM;
      end else if (ch == CH_OPEN) begin
        s = flush(s);
        if (d == DEPTH_MAX) begin
          ok = 1'b0;
        end else begin
          d  = d + 1'b1;
          s  = push(s, IT_OPEN);
          ok = pair_ok(s.older, s.prev);
        end
      end else if (ch == CH_CLOSE) begin
        s = flush(s);
        s = push(s, IT_CLOSE);
        if (d == '0) begin
          ok = 1'b0;
        end else begin
          d  = d - 1'b1;
          ok = pair_ok(s.older, s.prev);
        end
      end else if (ch inside {CH_PLUS, CH_MINUS}) begin
        s = flush(s);
        if (!pair_ok(s.older, s.prev)) begin
          ok = 1'b0;
        end else begin
          s  = push(s, (s.prev inside {IT_NONE, IT_OPEN}) ? IT_SIGN : IT_OP);
          ok = pair_ok(s.older, s.prev);
        end
      end else if (ch inside {CH_STAR, CH_SLASH, CH_CARET}) begin
        s  = flush(s);
        s  = push(s, IT_OP);
        ok = pair_ok(s.older, s.prev);
      end else if (ch inside {CH_SPACE, CH_CR, CH_LF}) begin
        s  = flush(s);
        ok = pair_ok(s.older, s.prev);
      end else if (ch inside {[CH_UC_LO:CH_UC_HI], [CH_LC_LO:CH_LC_HI]}) begin
        if (!s.name_flag) begin
          s = flush(s);
          if (!pair_ok(s.older, s.prev)) ok = 1'b0;
          else s.name_flag = 1'b1;
        end
        if (ok && s.pend == PK_NONE) s.pend = PK_NAME;
      end else begin
        ok = 1'b0;
      end

      if (!ok) begin
        s.err = 1'b1;
        ea    = pos;
      end else begin
        p = pos + 1'b1;
      end
    end

    res.status = ST_FINE;
    wide_pos   = '0;
    if (s.err) begin
      res.status = ST_ERROR;
      wide_pos   = 32'(ea);
    end else if (last) begin
      s = flush(s);
      if (!pair_ok(s.older, s.prev)) begin
        res.status = ST_ERROR;
        wide_pos   = 32'(p);
      end else if (d != '0) begin
        res.status = ST_UNCLOSED;
        wide_pos   = 32'(p);
      end else begin
        res.status = ST_ACCEPT;
      end
    end
    res.err_pos = wide_pos[ERR_POS_W-1:0];
    res.item    = s.prev;

    st_nxt     = s;
    depth_nxt  = d;
    pos_nxt    = p;
    err_at_nxt = ea;
  end

endmodule

// ----- verif/etsc_checker.sv -----
// Checker for the expression syntax checker: tracks the tokenizer and compares every verdict.
module etsc_checker (
  input  logic clk,
  input  logic rst_n,
  etsc_in_if   in_mon,
  etsc_out_if  out_mon,
  output int   mismatches,
  output int   verdicts_pending
);
  import etsc_pkg::*;

  localparam int DEPTH_BITS    = 8;
  localparam int POSITION_BITS = 16;
  localparam logic [DEPTH_BITS-1:0]    DEPTH_TOP = '1;
  localparam logic [POSITION_BITS-1:0] POS_TOP   = '1;

  // Tokenizer copy
  item_t                    newest;
  item_t                    prior;
  pend_t                    pend;
  bit                       num_open;
  bit                       name_open;
  bit                       point_seen;
  logic [DEPTH_BITS-1:0]    depth;
  logic [POSITION_BITS-1:0] char_pos;
  bit                       err_hit;
  logic [POSITION_BITS-1:0] err_at;

  result_t verdicts_due[$];
  result_t want;
  int      miss_count;

  function automatic void reset_tokenizer();
    newest     = IT_NONE;
    prior      = IT_NONE;
    pend       = PK_NONE;
    num_open   = 1'b0;
    name_open  = 1'b0;
    point_seen = 1'b0;
    depth      = '0;
    char_pos   = '0;
    err_hit    = 1'b0;
    err_at     = '0;
  endfunction

  function automatic bit pair_legal(item_t a, item_t b);
    case (a)
      IT_NUM, IT_CLOSE: return b == IT_OP || b == IT_CLOSE;
      IT_OPEN, IT_OP:   return b != IT_OP && b != IT_CLOSE;
      IT_SIGN:          return b == IT_NUM || b == IT_OPEN;
      IT_FUNC:          return b == IT_OPEN;
      default:          return 1'b1;
    endcase
  endfunction

  function automatic void push_item(item_t t);
    prior  = newest;
    newest = t;
  endfunction

  function automatic bit tail_legal();
    return prior == IT_NONE || pair_legal(prior, newest);
  endfunction

  // Flushing clears only the flag of the token's own kind.
  function automatic void flush_token();
    if (pend == PK_NAME) begin
      push_item(IT_FUNC);
      name_open = 1'b0;
    end else if (pend == PK_NUM) begin
      push_item(IT_NUM);
      num_open = 1'b0;
    end
    pend = PK_NONE;
  endfunction

  function automatic bit take_char(logic [7:0] c);
    bit digit;
    bit alpha;
    digit = c >= CH_DIG_LO && c <= CH_DIG_HI;
    alpha = (c >= CH_UC_LO && c <= CH_UC_HI) || (c >= CH_LC_LO && c <= CH_LC_HI);
    if (digit || c == CH_POINT) begin
      if (!num_open) begin
        if (newest == IT_NUM) return 1'b0;
        num_open   = 1'b1;
        point_seen = 1'b0;
      end
      if (c == CH_POINT) begin
        if (point_seen) return 1'b0;
        point_seen = 1'b1;
      end
      if (pend == PK_NONE) pend = PK_NUM;
      return 1'b1;
    end
    if (c == CH_OPEN) begin
      flush_token();
      if (depth == DEPTH_TOP) return 1'b0;
      depth++;
      push_item(IT_OPEN);
      return tail_legal();
    end
    if (c == CH_CLOSE) begin
      flush_token();
      push_item(IT_CLOSE);
      if (depth == '0) return 1'b0;
      depth--;
      return tail_legal();
    end
    if (c == CH_PLUS || c == CH_MINUS) begin
      flush_token();
      if (!tail_legal()) return 1'b0;
      push_item((newest == IT_NONE || newest == IT_OPEN) ? IT_SIGN : IT_OP);
      return tail_legal();
    end
    if (c == CH_STAR || c == CH_SLASH || c == CH_CARET) begin
      flush_token();
      push_item(IT_OP);
      return tail_legal();
    end
    if (c == CH_SPACE || c == CH_CR || c == CH_LF) begin
      flush_token();
      return tail_legal();
    end
    if (alpha) begin
      if (!name_open) begin
        flush_token();
        if (!tail_legal()) return 1'b0;
        name_open = 1'b1;
      end
      if (pend == PK_NONE) pend = PK_NAME;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t next_verdict(logic [7:0] c, logic fin);
    result_t r;
    bit      ok;
    r.status  = ST_FINE;
    r.err_pos = '0;
    if (!err_hit) begin
      ok = 1'b0;
      if (char_pos != POS_TOP) ok = take_char(c);
      if (!ok) begin
        err_hit = 1'b1;
        err_at  = char_pos;
      end else begin
        char_pos = char_pos + 1'b1;
      end
    end
    if (err_hit) begin
      r.status  = ST_ERROR;
      r.err_pos = ERR_POS_W'(err_at);
    end else if (fin) begin
      flush_token();
      if (!tail_legal()) begin
        r.status  = ST_ERROR;
        r.err_pos = ERR_POS_W'(char_pos);
      end else if (depth != '0) begin
        r.status  = ST_UNCLOSED;
        r.err_pos = ERR_POS_W'(char_pos);
      end else begin
        r.status = ST_ACCEPT;
      end
    end
    r.item = newest;
    if (fin) reset_tokenizer();
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_tokenizer();
      verdicts_due.delete();
      miss_count = 0;
      mismatches       <= 0;
      verdicts_pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        verdicts_due.push_back(next_verdict(in_mon.ch, in_mon.last));
      if (out_mon.valid && out_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transaction with none due");
          miss_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            miss_count++;
          end
          if (out_mon.err_pos !== want.err_pos) begin
            $error("err_pos: expected %0d, got %0d", want.err_pos, out_mon.err_pos);
            miss_count++;
          end
          if (out_mon.last_item_type !== want.item) begin
            $error("last_item_type: expected %0d, got %0d", want.item,
                   out_mon.last_item_type);
            miss_count++;
          end
        end
      end
      mismatches       <= miss_count;
      verdicts_pending <= verdicts_due.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the expression syntax checker testbench: clock, reset, character stimulus, verdict.
module testbench;
  import etsc_pkg::*;

  // Watchdog: cycles without any transaction before the run is called dead.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last verdict, to catch stray extra transactions.
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_CHARS = 900;

  // Characters that steer the tokenizer, used when corrupting an expression.
  localparam logic [7:0] PUNCT [11] = '{CH_OPEN, CH_CLOSE, CH_PLUS, CH_MINUS, CH_STAR,
                                        CH_SLASH, CH_CARET, CH_POINT, CH_SPACE, CH_CR, CH_LF};

  logic clk;
  logic rst_n;

  etsc_in_if  in_ch ();
  etsc_out_if verdict_ch ();

  int fail_count;
  int due_count;

  // Both sides skip idling while this is set.
  bit no_idle;
  int chars_sent;

  logic [7:0] expr_text[$];

  expression_token_syntax_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (verdict_ch)
  );

  etsc_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (verdict_ch),
    .mismatches       (fail_count),
    .verdicts_pending (due_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One character transaction. valid stays up across back-to-back
  // characters; it only drops when a gap is drawn, so it never gets two
  // updates in one step.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(16, 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ch    <= c;
    in_ch.last  <= fin;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
  endtask

  // Sends expr_text as one expression, last set on its final character.
  task automatic send_expression();
    for (int i = 0; i < expr_text.size(); i++)
      send_char(expr_text[i], i == expr_text.size() - 1);
  endtask

  task automatic send_text(input string s);
    expr_text.delete();
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
    send_expression();
  endtask

  task automatic push_number();
    int  len;
    int  dot;
    len = $urandom_range(4, 1);
    // dot lands past the end most of the time, so most numbers are integers
    dot = $urandom_range(2 * len, 0);
    for (int i = 0; i < len; i++)
      expr_text.push_back(i == dot ? CH_POINT : CH_DIG_LO + 8'($urandom_range(9, 0)));
  endtask

  // Random expression: mostly well formed (operand/operator alternation,
  // balanced brackets, function calls, signs where a sign is legal, blanks
  // between tokens), then now and then left unclosed or corrupted.
  // A small share is pure byte noise.
  task automatic make_expression();
    int  tokens;
    int  open;
    int  k;
    bit  operand;
    bit  sign_ok;
    int  name_len;
    expr_text.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(8, 1)) expr_text.push_back(8'($urandom_range(255, 0)));
      return;
    end
    open    = 0;
    operand = 1'b1;
    sign_ok = 1'b1;
    tokens  = $urandom_range(10, 1);
    repeat (tokens) begin
      if ($urandom_range(3, 0) == 0) begin
        case ($urandom_range(2, 0))
          0:       expr_text.push_back(CH_SPACE);
          1:       expr_text.push_back(CH_CR);
          default: expr_text.push_back(CH_LF);
        endcase
      end
      if (operand) begin
        case ($urandom_range(5, 0))
          0: begin
            if (sign_ok) begin
              expr_text.push_back($urandom_range(1, 0) ? CH_PLUS : CH_MINUS);
              sign_ok = 1'b0;
            end else begin
              push_number();
              operand = 1'b0;
            end
          end
          1: begin
            expr_text.push_back(CH_OPEN);
            open++;
            sign_ok = 1'b1;
          end
          2: begin
            // function call; digits may follow the first letter
            name_len = $urandom_range(4, 1);
            for (int i = 0; i < name_len; i++) begin
              if (i > 0 && $urandom_range(3, 0) == 0)
                expr_text.push_back(CH_DIG_LO + 8'($urandom_range(9, 0)));
              else if ($urandom_range(1, 0))
                expr_text.push_back(CH_UC_LO + 8'($urandom_range(25, 0)));
              else
                expr_text.push_back(CH_LC_LO + 8'($urandom_range(25, 0)));
            end
            expr_text.push_back(CH_OPEN);
            open++;
            sign_ok = 1'b1;
          end
          default: begin
            push_number();
            operand = 1'b0;
          end
        endcase
      end else begin
        if (open > 0 && $urandom_range(2, 0) == 0) begin
          expr_text.push_back(CH_CLOSE);
          open--;
        end else begin
          case ($urandom_range(4, 0))
            0:       expr_text.push_back(CH_PLUS);
            1:       expr_text.push_back(CH_MINUS);
            2:       expr_text.push_back(CH_STAR);
            3:       expr_text.push_back(CH_SLASH);
            default: expr_text.push_back(CH_CARET);
          endcase
          operand = 1'b1;
          sign_ok = 1'b0;
        end
      end
    end
    if (operand) push_number();
    if ($urandom_range(7, 0) != 0)
      repeat (open) expr_text.push_back(CH_CLOSE);
    // occasional corruption: overwrite, insert or drop one character
    if ($urandom_range(4, 0) == 0) begin
      k = $urandom_range(expr_text.size() - 1, 0);
      case ($urandom_range(2, 0))
        0:       expr_text[k] = 8'($urandom_range(255, 0));
        1:       expr_text.insert(k, PUNCT[$urandom_range(10, 0)]);
        default: if (expr_text.size() > 1) expr_text.delete(k);
      endcase
    end
  endtask

  // Verdict side: random stalls before each transaction.
  initial begin
    int stall;
    verdict_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(16, 0);
      if (stall != 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      verdict_ch.ready <= 1'b1;
      do @(posedge clk); while (!verdict_ch.valid);
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("expression_token_syntax_checker: mismatch");
    $finish;
  end

  initial begin
    no_idle     = 1'b0;
    chars_sent  = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.ch    <= '0;
    in_ch.last  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed expressions
    send_text("-(4/.5)\r*1\n");  // signs, brackets, blanks, point-led number
    send_text("a1 2^b");         // digit after a name with digits skips new-number checks,
                                 // and the number flushed by '^' is never paired with the name
    send_text("1.2.");           // second point
    send_text("7 8");            // number after number
    send_text(")");              // close at depth zero
    send_text("2+");             // trailing operator still passes
    send_text("-a");             // sign then name fails at the end check
    send_text("(.5");            // unclosed bracket
    expr_text = '{8'h00};        // illegal character alone
    send_expression();
    expr_text = '{8'hFF, "1"};   // illegal top code, then ignored until last
    send_expression();

    // Long case without idling on either side.
    no_idle = 1'b1;
    // one open too many for the depth counter, then a close that is ignored
    expr_text.delete();
    repeat (256) expr_text.push_back(CH_OPEN);
    expr_text.push_back(CH_CLOSE);
    send_expression();

    // Random expressions, some with idling switched off
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      no_idle = ($urandom_range(7, 0) == 0);
      make_expression();
      send_expression();
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (due_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("expression_token_syntax_checker: match");
    else
      $display("expression_token_syntax_checker: mismatch");
    $finish;
  end

endmodule
